[rtl/modbus_fc03_response_receiver_assert.svh]
// Assertion macros for the function-3 reply receiver.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef MODBUS_FC03_RESPONSE_RECEIVER_ASSERT_SVH
`define MODBUS_FC03_RESPONSE_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MFR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define MFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define MFR_ASSERT_IMPLY(lbl, ante, cons)
`define MFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/mfr_pkg.sv]
package mfr_pkg;

    // frame and register limits
    localparam int unsigned MAX_FRAME   = 256;
    localparam int unsigned MAX_REGS    = 125;
    localparam int unsigned FRAME_W     = 9;
    localparam int unsigned REG_IDX_W   = 7;
    localparam int unsigned MIN_FRAME   = 5;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // CRC and protocol constants
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
    localparam int unsigned FUNC_EXC_BIT   = 7;

    // configuration
    localparam int unsigned APB_ADDR_W        = 3;
    localparam logic        CFG_IDX_TIMEOUT   = 1'b0;
    localparam logic        CFG_IDX_REG_COUNT = 1'b1;
    localparam logic [15:0] TIMEOUT_RST       = 16'd100;
    localparam logic [6:0]  REG_COUNT_RST     = 7'd1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic {
        KIND_REG     = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        VERD_VALID       = 3'd0,
        VERD_NO_REPLY    = 3'd1,
        VERD_SHORT       = 3'd2,
        VERD_WRONG_SLAVE = 3'd3,
        VERD_CRC_BAD     = 3'd4,
        VERD_EXCEPTION   = 3'd5,
        VERD_WRONG_FUNC  = 3'd6
    } t_verdict;

    // classified command: data is the slave address on start, the byte otherwise
    typedef struct packed {
        t_opcode    op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_xfer;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [6:0]  reg_count;
    } t_cfg;

    typedef struct packed {
        t_kind                kind;
        logic [REG_IDX_W-1:0] reg_index;
        logic [15:0]          reg_value;
        t_verdict             verdict;
        logic [FRAME_W-1:0]   frame_bytes;
        logic [7:0]           found_count;
    } t_result;

    // one byte through the reflected Modbus CRC-16
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {8'h00, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return {8'h00, crc[15:8]} ^ c;
    endfunction

endpackage

[rtl/mfr_if.sv]
// input channel
interface mfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] slave_addr;

    modport source (output valid, output opcode, output rx_byte, output slave_addr,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input slave_addr,
                    output ready);
endinterface

// result channel
interface mfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  verdict;
    logic [8:0]  frame_bytes;
    logic [7:0]  found_count;

    modport source (output valid, output kind, output reg_index, output reg_value,
                    output verdict, output frame_bytes, output found_count,
                    input ready);
    modport sink   (input valid, input kind, input reg_index, input reg_value,
                    input verdict, input frame_bytes, input found_count,
                    output ready);
endinterface

[rtl/modbus_fc03_response_receiver.sv]
// Channel   Dir  Handshake       Payload
// i_in      in   valid/ready     opcode, rx_byte, slave_addr
// o_out     out  valid/ready     kind, reg_index, reg_value, verdict, frame_bytes, found_count
// APB       in   psel/penable    timeout_ticks at 0x0, reg_count at 0x4
//
// One transaction per cycle in sustained flow while the output does not stall;
// a result reaches the output register through the queue, then execution.
// The two-entry command queue lets input keep flowing for two transactions
// while the output stalls; after that i_in.ready drops.
// Synchronous active-low reset; no clearing pass, input ready from the first
// cycle after reset.
`include "modbus_fc03_response_receiver_assert.svh"

module modbus_fc03_response_receiver import mfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mfr_in_if.sink                i_in,
    mfr_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] r_timeout;
    logic [6:0]  r_reg_count;
    logic        w_cfg_wr;
    t_cfg        w_cfg;
    t_cmd_xfer   w_push;
    t_cmd_xfer   w_head;
    logic        w_q_full;
    logic        w_pop;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_reg_count <= REG_COUNT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == CFG_IDX_TIMEOUT) begin
                r_timeout <= pwdata[15:0];
            end else begin
                r_reg_count <= pwdata[6:0];
            end
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_REG_COUNT) ? {25'd0, r_reg_count}
                                                   : {16'd0, r_timeout};

    assign w_cfg.timeout_ticks = r_timeout;
    assign w_cfg.reg_count     = r_reg_count;

    mfr_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    mfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    mfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_cfg   (w_cfg),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // a command pushed into an empty queue is at its head next cycle
    `MFR_ASSERT_NEXT(a_queue_head, w_push.valid && !w_head.valid, w_head.valid)
    // a valid verdict has already been counted
    `MFR_ASSERT_IMPLY(a_found_counted, o_out.valid && o_out.kind == KIND_VERDICT && o_out.verdict == VERD_VALID, o_out.found_count != 8'd0)
    // register values come only from complete pairs after the header
    `MFR_ASSERT_IMPLY(a_pair_position, o_out.valid && o_out.kind == KIND_REG, o_out.frame_bytes >= 9'd5 && o_out.frame_bytes[0])
    // a short frame has between one and four bytes
    `MFR_ASSERT_IMPLY(a_short_len, o_out.valid && o_out.kind == KIND_VERDICT && o_out.verdict == VERD_SHORT, o_out.frame_bytes != 9'd0 && o_out.frame_bytes < 9'd5)

endmodule

[rtl/mfr_front.sv]
module mfr_front import mfr_pkg::*; (
    mfr_in_if.sink    i_in,
    input  logic      i_q_full,
    output t_cmd_xfer o_push
);

    logic w_known;

    // accept whenever the queue has room
    assign i_in.ready = !i_q_full;

    // classify the opcode; unknown codes are taken and dropped
    always_comb begin
        o_push.cmd.op   = OP_BYTE;
        o_push.cmd.data = i_in.rx_byte;
        w_known         = 1'b1;
        case (i_in.opcode)
            OP_START: begin
                o_push.cmd.op   = OP_START;
                o_push.cmd.data = i_in.slave_addr;
            end
            OP_BYTE: begin
                o_push.cmd.op = OP_BYTE;
            end
            OP_TICK: begin
                o_push.cmd.op = OP_TICK;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
        o_push.valid = i_in.valid && !i_q_full && w_known;
    end

endmodule

[rtl/mfr_queue.sv]
module mfr_queue import mfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_xfer i_push,
    input  logic      i_pop,
    output logic      o_full,
    output t_cmd_xfer o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push.valid, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

[rtl/mfr_back.sv]
module mfr_back import mfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_xfer  i_head,
    input  t_cfg       i_cfg,
    output logic       o_pop,
    mfr_out_if.source  o_out
);

    // frame state
    logic               r_armed,     n_armed;
    logic [7:0]         r_wanted,    n_wanted;
    logic [FRAME_W-1:0] r_bytes,     n_bytes;
    logic [7:0]         r_addr,      n_addr;
    logic [7:0]         r_func,      n_func;
    logic [7:0]         r_count,     n_count;
    logic [15:0]        r_crc,       n_crc;
    logic [7:0]         r_old,       n_old;
    logic [7:0]         r_new,       n_new;
    logic [7:0]         r_data_high, n_data_high;
    logic [15:0]        r_ticks,     n_ticks;
    logic [7:0]         r_found,     n_found;
    // output register
    logic               r_out_valid, n_out_valid;
    t_result            r_res,       n_res;

    logic                 w_judge;
    logic                 w_pair;
    logic [REG_IDX_W-1:0] w_idx;
    logic [FRAME_W-1:0]   w_expected;
    t_verdict             w_verdict;

    // take a command when the output register is free or being drained
    assign o_pop = i_head.valid && (!r_out_valid || o_out.ready);

    // command execution
    always_comb begin
        n_armed     = r_armed;
        n_wanted    = r_wanted;
        n_bytes     = r_bytes;
        n_addr      = r_addr;
        n_func      = r_func;
        n_count     = r_count;
        n_crc       = r_crc;
        n_old       = r_old;
        n_new       = r_new;
        n_data_high = r_data_high;
        n_ticks     = r_ticks;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_out.ready;
        n_res       = r_res;
        w_judge     = 1'b0;
        w_pair      = 1'b0;
        w_idx       = 7'((r_bytes - 9'd4) >> 1);
        w_expected  = '0;
        w_verdict   = VERD_VALID;

        if (o_pop) begin
            case (i_head.cmd.op)
                OP_START: begin
                    n_armed     = 1'b1;
                    n_wanted    = i_head.cmd.data;
                    n_bytes     = '0;
                    n_addr      = '0;
                    n_func      = '0;
                    n_count     = '0;
                    n_crc       = CRC_INIT;
                    n_old       = '0;
                    n_new       = '0;
                    n_data_high = '0;
                    n_ticks     = '0;
                end
                OP_TICK: begin
                    if (r_armed) begin
                        n_ticks = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 1'b1;
                        w_judge = (n_ticks >= i_cfg.timeout_ticks);
                    end
                end
                OP_BYTE: begin
                    if (r_armed) begin
                        // CRC lags two bytes behind so the trailer is left out
                        if (r_bytes >= 9'd2) begin
                            n_crc = crc_fold(r_crc, r_old);
                        end
                        n_old = r_new;
                        n_new = i_head.cmd.data;
                        if (r_bytes == 9'd0) begin
                            n_addr = i_head.cmd.data;
                        end else if (r_bytes == 9'd1) begin
                            n_func = i_head.cmd.data;
                        end else if (r_bytes == 9'd2) begin
                            n_count = i_head.cmd.data;
                        end else if (r_bytes[0]) begin
                            n_data_high = i_head.cmd.data;
                        end else begin
                            w_pair = !r_func[FUNC_EXC_BIT]
                                     && (r_bytes <= 9'd2 + {1'b0, r_count})
                                     && (w_idx < i_cfg.reg_count)
                                     && (w_idx < REG_IDX_W'(MAX_REGS));
                        end
                        n_bytes    = r_bytes + 1'b1;
                        w_expected = n_func[FUNC_EXC_BIT] ? FRAME_W'(MIN_FRAME)
                                     : FRAME_W'(MIN_FRAME) + {1'b0, n_count};
                        w_judge    = (n_bytes >= FRAME_W'(MAX_FRAME))
                                     || ((n_bytes >= FRAME_W'(MIN_FRAME))
                                         && (n_bytes >= w_expected));
                    end
                end
                default: begin
                end
            endcase
        end

        // verdict in priority order
        if (n_bytes == '0) begin
            w_verdict = VERD_NO_REPLY;
        end else if (n_bytes < FRAME_W'(MIN_FRAME)) begin
            w_verdict = VERD_SHORT;
        end else if (n_addr != r_wanted) begin
            w_verdict = VERD_WRONG_SLAVE;
        end else if (n_crc != {n_new, n_old}) begin
            w_verdict = VERD_CRC_BAD;
        end else if (n_func[FUNC_EXC_BIT]) begin
            w_verdict = VERD_EXCEPTION;
        end else if (n_func != FUNC_READ_HOLD) begin
            w_verdict = VERD_WRONG_FUNC;
        end else begin
            w_verdict = VERD_VALID;
        end

        // load the output register; a verdict wins over a pair
        if (w_judge) begin
            n_armed = 1'b0;
            if (w_verdict == VERD_VALID && r_found != 8'hFF) begin
                n_found = r_found + 1'b1;
            end
            n_res.kind        = KIND_VERDICT;
            n_res.reg_index   = '0;
            n_res.reg_value   = '0;
            n_res.verdict     = w_verdict;
            n_res.frame_bytes = n_bytes;
            n_res.found_count = n_found;
            n_out_valid       = 1'b1;
        end else if (w_pair) begin
            n_res.kind        = KIND_REG;
            n_res.reg_index   = w_idx;
            n_res.reg_value   = {r_data_high, i_head.cmd.data};
            n_res.verdict     = VERD_VALID;
            n_res.frame_bytes = n_bytes;
            n_res.found_count = r_found;
            n_out_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_wanted    <= '0;
            r_bytes     <= '0;
            r_addr      <= '0;
            r_func      <= '0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_old       <= '0;
            r_new       <= '0;
            r_data_high <= '0;
            r_ticks     <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_armed     <= n_armed;
            r_wanted    <= n_wanted;
            r_bytes     <= n_bytes;
            r_addr      <= n_addr;
            r_func      <= n_func;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_old       <= n_old;
            r_new       <= n_new;
            r_data_high <= n_data_high;
            r_ticks     <= n_ticks;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_res.kind;
    assign o_out.reg_index   = r_res.reg_index;
    assign o_out.reg_value   = r_res.reg_value;
    assign o_out.verdict     = r_res.verdict;
    assign o_out.frame_bytes = r_res.frame_bytes;
    assign o_out.found_count = r_res.found_count;

endmodule

[dv/mfr_reply_checker.sv]
// Helper shared by the bench and the checker: serial Modbus CRC-16 update
package mfr_tb_pkg;
    import mfr_pkg::*;

    // bit-serial form, one byte per call
    function automatic logic [15:0] modbus_crc_add(input logic [15:0] acc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage

// Watches both channels and the config port, predicts every result and
// compares it with what leaves the block.
module mfr_reply_checker import mfr_pkg::*, mfr_tb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mfr_in_if                     i_in_mon,
    mfr_out_if                    i_out_mon,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_pending
);

    // configuration copy
    logic [15:0] cfg_timeout;
    logic [6:0]  cfg_regs;

    // receiver state copy
    logic        armed;
    logic [7:0]  want_slave;
    logic [8:0]  nbytes;
    logic [7:0]  hdr_addr;
    logic [7:0]  hdr_func;
    logic [7:0]  hdr_count;
    logic [15:0] crc_run;
    logic [7:0]  tail [2];   // [0] older, [1] newer
    logic [7:0]  data_hi;
    logic [15:0] ticks;
    logic [7:0]  valid_total;

    t_result     pending_results [$];
    int          fail_total = 0;

    assign o_errors = fail_total;

    function automatic void clear_frame_state();
        armed      = 1'b0;
        want_slave = '0;
        nbytes     = '0;
        hdr_addr   = '0;
        hdr_func   = '0;
        hdr_count  = '0;
        crc_run    = CRC_INIT;
        tail[0]    = '0;
        tail[1]    = '0;
        data_hi    = '0;
        ticks      = '0;
    endfunction

    // judge the frame as it stands and go idle
    function automatic t_result judge_frame();
        t_result  r;
        t_verdict v;
        if (nbytes == 0)
            v = VERD_NO_REPLY;
        else if (nbytes < MIN_FRAME)
            v = VERD_SHORT;
        else if (hdr_addr != want_slave)
            v = VERD_WRONG_SLAVE;
        else if (crc_run != {tail[1], tail[0]})
            v = VERD_CRC_BAD;
        else if (hdr_func[FUNC_EXC_BIT])
            v = VERD_EXCEPTION;
        else if (hdr_func != FUNC_READ_HOLD)
            v = VERD_WRONG_FUNC;
        else
            v = VERD_VALID;
        if (v == VERD_VALID && valid_total != 8'hFF)
            valid_total++;
        r             = '0;
        r.kind        = KIND_VERDICT;
        r.verdict     = v;
        r.frame_bytes = nbytes;
        r.found_count = valid_total;
        armed         = 1'b0;
        return r;
    endfunction

    // one input transaction; returns 1 when it produces a result
    function automatic bit advance_receiver(input logic [1:0] op, input logic [7:0] rx,
                                            input logic [7:0] sa, output t_result res);
        int unsigned pos;
        int unsigned need;
        int unsigned idx;
        bit          pair;
        logic [15:0] val;
        res  = '0;
        pair = 1'b0;
        idx  = 0;
        val  = '0;
        if (op == OP_START) begin
            clear_frame_state();
            armed      = 1'b1;
            want_slave = sa;
            return 1'b0;
        end
        if (!armed)
            return 1'b0;
        if (op == OP_TICK) begin
            if (ticks != 16'hFFFF)
                ticks++;
            if (ticks >= cfg_timeout) begin
                res = judge_frame();
                return 1'b1;
            end
            return 1'b0;
        end
        if (op != OP_BYTE)
            return 1'b0;

        // CRC trails the newest two bytes
        pos = nbytes;
        if (pos >= 2)
            crc_run = modbus_crc_add(crc_run, tail[0]);
        tail[0] = tail[1];
        tail[1] = rx;

        if (pos == 0)
            hdr_addr = rx;
        else if (pos == 1)
            hdr_func = rx;
        else if (pos == 2)
            hdr_count = rx;
        else if (pos % 2 == 1)
            data_hi = rx;
        else begin
            idx  = (pos - 4) >> 1;
            val  = {data_hi, rx};
            pair = !hdr_func[FUNC_EXC_BIT] && pos <= 2 + int'(hdr_count) &&
                   idx < cfg_regs && idx < MAX_REGS;
        end
        nbytes = 9'(pos + 1);

        if (nbytes >= MAX_FRAME) begin
            res = judge_frame();
            return 1'b1;
        end
        if (nbytes >= MIN_FRAME) begin
            need = hdr_func[FUNC_EXC_BIT] ? MIN_FRAME : MIN_FRAME + hdr_count;
            if (nbytes >= need) begin
                res = judge_frame();
                return 1'b1;
            end
        end
        if (pair) begin
            res.kind        = KIND_REG;
            res.reg_index   = 7'(idx);
            res.reg_value   = val;
            res.frame_bytes = nbytes;
            res.found_count = valid_total;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_total++;
        end
    endtask

    // result first, then config, then the new input transaction
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result res;
        if (!i_rst_n) begin
            cfg_timeout = TIMEOUT_RST;
            cfg_regs    = REG_COUNT_RST;
            valid_total = '0;
            clear_frame_state();
            pending_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual kind %0d verdict %0d",
                             $time, i_out_mon.kind, i_out_mon.verdict);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(i_out_mon.kind));
                    check_field("reg_index", 16'(want.reg_index), 16'(i_out_mon.reg_index));
                    check_field("reg_value", want.reg_value, i_out_mon.reg_value);
                    check_field("verdict", 16'(want.verdict), 16'(i_out_mon.verdict));
                    check_field("frame_bytes", 16'(want.frame_bytes),
                                16'(i_out_mon.frame_bytes));
                    check_field("found_count", 16'(want.found_count),
                                16'(i_out_mon.found_count));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == CFG_IDX_REG_COUNT)
                    cfg_regs = i_pwdata[6:0];
                else
                    cfg_timeout = i_pwdata[15:0];
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (advance_receiver(i_in_mon.opcode, i_in_mon.rx_byte, i_in_mon.slave_addr,
                                     res))
                    pending_results.push_back(res);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

[dv/tb_modbus_fc03_response_receiver.sv]
module tb_modbus_fc03_response_receiver;
    import mfr_pkg::*;
    import mfr_tb_pkg::*;

    // opcode with no meaning to the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         N_PHASES  = 9;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int chk_errors;
    int chk_pending;
    int items_sent  = 0;
    int tx_idle_pct = 26;
    int rx_idle_pct = 72;
    int cur_timeout = TIMEOUT_RST;

    int unsigned phase_timeout [N_PHASES] = '{1, 0, 65535, 20, 7, 40, 30, 12, 0};
    int unsigned phase_regs    [N_PHASES] = '{125, 0, 127, 1, 64, 3, 125, 10, 0};

    mfr_in_if  in_bus ();
    mfr_out_if out_bus ();

    modbus_fc03_response_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mfr_reply_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_bus),
        .i_out_mon (out_bus),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result-side backpressure
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one input transaction, with random gaps in front
    task automatic put_item(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] sa);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.opcode     <= op;
        in_bus.rx_byte    <= rx;
        in_bus.slave_addr <= sa;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // drop valid and wait for every predicted result to drain
    task automatic settle();
        int n;
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        n = 0;
        while (chk_pending != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned timeout, input int unsigned regs);
        apb_write(CFG_IDX_TIMEOUT, timeout);
        apb_write(CFG_IDX_REG_COUNT, regs);
        cur_timeout = timeout;
    endtask

    // start, then the reply bytes up to 'keep', with the odd tick mixed in
    task automatic send_reply(input logic [7:0] sa, input logic [7:0] addr,
                              input logic [7:0] func, input logic [7:0] cnt,
                              input bit bad_crc, input int keep);
        logic [7:0]  frame [$];
        logic [15:0] crc;
        int          bit_no;
        frame = {};
        frame.push_back(addr);
        frame.push_back(func);
        if (func[FUNC_EXC_BIT])
            frame.push_back(8'($urandom));
        else begin
            frame.push_back(cnt);
            repeat (cnt) frame.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        foreach (frame[k])
            crc = modbus_crc_add(crc, frame[k]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        if (bad_crc) begin
            bit_no = $urandom_range(frame.size() * 8 - 1);
            frame[bit_no / 8] = frame[bit_no / 8] ^ (8'd1 << (bit_no % 8));
        end
        put_item(OP_START, 8'($urandom), sa);
        foreach (frame[k]) begin
            if (k >= keep)
                break;
            if ($urandom_range(99) < 3)
                put_item(OP_TICK, 8'($urandom), 8'($urandom));
            put_item(OP_BYTE, frame[k], 8'($urandom));
        end
    endtask

    // random replies, about half well-formed, the rest broken or noise
    task automatic run_phase(input int n_items, input bit open_long);
        int         stop;
        int         r;
        int         keep;
        bit         bad;
        logic [7:0] sa;
        logic [7:0] addr;
        logic [7:0] func;
        logic [7:0] cnt;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            if (items_sent < 650) begin
                tx_idle_pct = 26;
                rx_idle_pct = 72;
            end else if (items_sent < 1300) begin
                tx_idle_pct = 72;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sa   = 8'($urandom_range(247, 1));
            addr = sa;
            func = FUNC_READ_HOLD;
            bad  = 1'b0;
            keep = 1000;
            cnt  = 8'(2 * $urandom_range(9));
            if ($urandom_range(9) == 0)
                cnt = 8'($urandom_range(24));
            // long replies run into the frame size limit
            if (open_long || $urandom_range(99) < 2)
                cnt = 8'($urandom_range(255, 251));
            open_long = 1'b0;
            r = $urandom_range(99);
            if (r < 50) begin
            end else if (r < 60) begin
                func = 8'($urandom) | 8'h80;
            end else if (r < 67) begin
                addr = sa ^ (8'd1 << $urandom_range(7));
            end else if (r < 77) begin
                bad = 1'b1;
            end else if (r < 85) begin
                func = 8'($urandom_range(127));
                if (func == FUNC_READ_HOLD)
                    func = 8'h04;
            end else if (r < 93) begin
                keep = $urandom_range(8);
            end
            if (r < 93) begin
                send_reply(sa, addr, func, cnt, bad, keep);
                // let a cut-off reply time out where that is cheap
                if (keep < 1000 && cur_timeout <= 40)
                    repeat (cur_timeout > 0 ? cur_timeout : 1)
                        put_item(OP_TICK, 8'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(6, 1))
                    put_item(2'($urandom_range(3)), 8'($urandom),
                             8'($urandom_range(247, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.opcode     <= OP_START;
        in_bus.rx_byte    <= '0;
        in_bus.slave_addr <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte, tick and unused opcode while idle are ignored
        put_item(OP_BYTE, 8'hFF, 8'h00);
        put_item(OP_TICK, 8'h00, 8'hFF);
        put_item(OP_UNUSED, 8'hA5, 8'h5A);
        settle();
        configure(3, 2);

        // no reply, then a short frame, both by timeout
        put_item(OP_START, 8'h00, 8'd1);
        repeat (3) put_item(OP_TICK, 8'h00, 8'h00);
        put_item(OP_START, 8'h00, 8'd247);
        put_item(OP_BYTE, 8'd247, 8'h00);
        put_item(OP_BYTE, FUNC_READ_HOLD, 8'h00);
        repeat (3) put_item(OP_TICK, 8'hFF, 8'hFF);

        // good reply with two registers, then an exception reply
        send_reply(8'h11, 8'h11, FUNC_READ_HOLD, 8'd4, 1'b0, 1000);
        send_reply(8'h22, 8'h22, 8'h83, 8'd0, 1'b0, 1000);

        // restart mid-frame drops it; unused opcode while armed; wrong function
        put_item(OP_START, 8'h00, 8'h40);
        put_item(OP_BYTE, 8'h40, 8'h00);
        put_item(OP_UNUSED, 8'h00, 8'h00);
        send_reply(8'h41, 8'h41, 8'h10, 8'd2, 1'b0, 1000);

        phase_timeout[N_PHASES-1] = $urandom_range(40, 2);
        phase_regs[N_PHASES-1]    = $urandom_range(125, 1);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            configure(phase_timeout[ph], phase_regs[ph]);
            run_phase(220, ph == 2);
        end
        settle();

        if (chk_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, chk_pending);
        if (chk_errors == 0 && chk_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mfr_pkg.sv
rtl/mfr_if.sv
rtl/mfr_front.sv
rtl/mfr_queue.sv
rtl/mfr_back.sv
rtl/modbus_fc03_response_receiver.sv
dv/mfr_reply_checker.sv
dv/tb_modbus_fc03_response_receiver.sv
